FILE: hw/rtl/apict_pkg.sv
package apict_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int VEC_WIDTH   = 8;
    localparam int DIV_WIDTH   = 4;
    localparam int PRE_WIDTH   = 7;

    localparam int MASK_BIT     = 16;
    localparam int PERIODIC_BIT = 17;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_LVT     = 2'd0;
    localparam logic [1:0] REG_INITIAL = 2'd1;
    localparam logic [1:0] REG_CURRENT = 2'd2;
    localparam logic [1:0] REG_DIVIDE  = 2'd3;

    localparam logic [DIV_WIDTH-1:0] DIVIDE_KEEP = 4'hB;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq_fire;
        logic [VEC_WIDTH-1:0]  irq_vector;
    } t_out_word;

    // Divisor as an 8-bit value: 2^(v+1) for v 0..6, 1 for v 7.
    function automatic logic [PRE_WIDTH:0] divisor_of(input logic [DIV_WIDTH-1:0] code);
        logic [2:0] v;
        v = {code[3], code[1:0]};
        if (v == 3'd7) begin
            return (PRE_WIDTH+1)'(1);
        end
        return (PRE_WIDTH+1)'(1) << (v + 3'd1);
    endfunction

endpackage

FILE: hw/rtl/apict_in_if.sv
interface apict_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  reg_select;
    logic [31:0] write_data;

    modport source (output valid, output kind, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_select, input write_data,
                    output ready);
endinterface

FILE: hw/rtl/apict_out_if.sv
interface apict_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_fire;
    logic [7:0]  irq_vector;

    modport source (output valid, output read_data, output irq_fire, output irq_vector,
                    input ready);
    modport sink   (input valid, input read_data, input irq_fire, input irq_vector,
                    output ready);
endinterface

FILE: hw/rtl/apic_countdown_timer.sv
// Local interrupt controller countdown timer.
// i_in carries one bus event per word: a bus-clock tick, a register write
// or a register read (reg_select picks the vector/mask/mode word, the
// initial count, the current count or the divide code).
// o_out returns exactly one word per accepted event: read data for a read,
// and irq_fire/irq_vector when a tick takes an unmasked count to zero.
// The result word is registered, in the skid register if the output is
// stalled. One event per cycle while i_in.ready is high; all timer state
// updates in the cycle the event is accepted.
// A two-entry output stage (result register plus skid register) keeps
// i_in.ready high while one result waits; ready drops only when both are
// full, i.e. once a further word is accepted while the output is stalled.
// Reset (i_rst_n low, synchronous): counts and vector zero, masked,
// one-shot, divide by two, prescaler zero, output stage empty.
module apic_countdown_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apict_in_if.sink    i_in,
    apict_out_if.source o_out
);
    import apict_pkg::*;

    t_count                r_initial, n_initial;
    t_count                r_current, n_current;
    logic [VEC_WIDTH-1:0]  r_vector, n_vector;
    logic                  r_masked, n_masked;
    logic                  r_periodic, n_periodic;
    logic [DIV_WIDTH-1:0]  r_divide, n_divide;
    logic [PRE_WIDTH-1:0]  r_prescaler, n_prescaler;

    t_out_word r_out, n_out;
    t_out_word r_skid, n_skid;
    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;

    t_out_word             res;
    logic                  accept;
    logic [PRE_WIDTH:0]    pre_next;
    logic [PRE_WIDTH:0]    divisor;
    t_count                dec;

    assign i_in.ready       = !r_skid_valid;
    assign accept           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out.read_data;
    assign o_out.irq_fire   = r_out.irq_fire;
    assign o_out.irq_vector = r_out.irq_vector;

    assign divisor  = divisor_of(r_divide);
    assign pre_next = {1'b0, r_prescaler} + (PRE_WIDTH+1)'(1);
    assign dec      = r_current - t_count'(1);

    // timer state and result word
    always_comb begin
        n_initial   = r_initial;
        n_current   = r_current;
        n_vector    = r_vector;
        n_masked    = r_masked;
        n_periodic  = r_periodic;
        n_divide    = r_divide;
        n_prescaler = r_prescaler;
        res         = '0;
        if (accept) begin
            unique case (i_in.kind)
                KIND_TICK: begin
                    if (pre_next < divisor) begin
                        n_prescaler = pre_next[PRE_WIDTH-1:0];
                    end else begin
                        n_prescaler = '0;
                        if (r_current != '0) begin
                            if (dec == '0) begin
                                n_current      = r_periodic ? r_initial : '0;
                                res.irq_fire   = !r_masked;
                                res.irq_vector = r_masked ? '0 : r_vector;
                            end else begin
                                n_current = dec;
                            end
                        end
                    end
                end
                KIND_WRITE: begin
                    unique case (i_in.reg_select)
                        REG_LVT: begin
                            n_vector   = i_in.write_data[VEC_WIDTH-1:0];
                            n_masked   = i_in.write_data[MASK_BIT];
                            n_periodic = i_in.write_data[PERIODIC_BIT];
                        end
                        REG_INITIAL: begin
                            n_initial   = i_in.write_data[COUNT_WIDTH-1:0];
                            n_current   = i_in.write_data[COUNT_WIDTH-1:0];
                            n_prescaler = '0;
                        end
                        REG_CURRENT: begin
                        end
                        REG_DIVIDE: begin
                            n_divide = i_in.write_data[DIV_WIDTH-1:0] & DIVIDE_KEEP;
                        end
                    endcase
                end
                KIND_READ: begin
                    unique case (i_in.reg_select)
                        REG_LVT: begin
                            res.read_data = DATA_WIDTH'(r_vector)
                                | (DATA_WIDTH'(r_masked) << MASK_BIT)
                                | (DATA_WIDTH'(r_periodic) << PERIODIC_BIT);
                        end
                        REG_INITIAL: res.read_data = DATA_WIDTH'(r_initial);
                        REG_CURRENT: res.read_data = DATA_WIDTH'(r_current);
                        REG_DIVIDE:  res.read_data = DATA_WIDTH'(r_divide);
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // output register with skid
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = res;
                n_skid_valid = accept;
            end else begin
                n_out       = res;
                n_out_valid = accept;
            end
        end else if (accept) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial    <= '0;
            r_current    <= '0;
            r_vector     <= '0;
            r_masked     <= 1'b1;
            r_periodic   <= 1'b0;
            r_divide     <= '0;
            r_prescaler  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_initial    <= n_initial;
            r_current    <= n_current;
            r_vector     <= n_vector;
            r_masked     <= n_masked;
            r_periodic   <= n_periodic;
            r_divide     <= n_divide;
            r_prescaler  <= n_prescaler;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_fire_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.irq_fire) |-> (o_out.read_data == '0))
        else $error("interrupt word carries read data");

    a_initial_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_WRITE && i_in.reg_select == REG_INITIAL)
        |=> (r_prescaler == '0 && r_current == r_initial))
        else $error("initial count write did not restart timer");

endmodule

FILE: bench/apic_countdown_timer_tb.sv
module apic_countdown_timer_tb;

    import apict_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int N_PHASES = 6;
    localparam int PHASE_EVENTS = 150;
    localparam int N_DIRECTED = 26;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  sel;
        logic [31:0] data;
        bit          pinned;
        t_out_word   word;
    } bus_row_t;

    // pinned rows carry their result word; the rest go through the timer model
    localparam bus_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{KIND_READ,  REG_LVT,     32'h0000_0000, 1'b1, '{32'h0001_0000, 1'b0, 8'h00}},
        '{KIND_READ,  REG_INITIAL, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_READ,  REG_DIVIDE,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_TICK,  REG_DIVIDE,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_WRITE, REG_LVT,     32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_READ,  REG_LVT,     32'h0000_0000, 1'b1, '{32'h0003_00FF, 1'b0, 8'h00}},
        '{KIND_WRITE, REG_DIVIDE,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_READ,  REG_DIVIDE,  32'h0000_0000, 1'b1, '{32'h0000_000B, 1'b0, 8'h00}},
        '{KIND_WRITE, REG_CURRENT, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_READ,  REG_CURRENT, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_WRITE, REG_INITIAL, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_READ,  REG_INITIAL, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 8'h00}},
        '{KIND_TICK,  REG_LVT,     32'h0000_0000, 1'b0, '0},
        '{KIND_WRITE, REG_LVT,     32'h0000_0042, 1'b0, '0},
        '{KIND_WRITE, REG_INITIAL, 32'h0000_0001, 1'b0, '0},
        '{KIND_TICK,  REG_LVT,     32'h0000_0000, 1'b0, '0},
        '{KIND_NONE,  REG_DIVIDE,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 8'h00}},
        '{KIND_WRITE, REG_DIVIDE,  32'h0000_000A, 1'b0, '0},
        '{KIND_WRITE, REG_INITIAL, 32'h0000_0003, 1'b0, '0},
        '{KIND_TICK,  REG_LVT,     32'h0000_0000, 1'b0, '0},
        '{KIND_TICK,  REG_LVT,     32'h0000_0000, 1'b0, '0},
        '{KIND_WRITE, REG_DIVIDE,  32'h0000_0000, 1'b0, '0},
        '{KIND_TICK,  REG_LVT,     32'h0000_0000, 1'b0, '0},
        '{KIND_READ,  REG_CURRENT, 32'h0000_0000, 1'b0, '0},
        '{KIND_WRITE, REG_INITIAL, 32'h0000_0000, 1'b0, '0},
        '{KIND_TICK,  REG_LVT,     32'h0000_0000, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    apict_in_if  in_ch();
    apict_out_if out_ch();

    apic_countdown_timer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // timer model state
    logic [COUNT_WIDTH-1:0] tmr_initial;
    logic [COUNT_WIDTH-1:0] tmr_current;
    logic [VEC_WIDTH-1:0]   tmr_vector;
    logic                   tmr_masked;
    logic                   tmr_periodic;
    logic [DIV_WIDTH-1:0]   tmr_divide;
    logic [PRE_WIDTH-1:0]   tmr_prescale;

    t_out_word pending_words[$];

    int tx_gap_pct;
    int rx_stall_pct;
    int cycle_count;
    int fail_count;
    int words_checked;
    int irq_count;
    int tick_count;
    int write_count;
    int read_count;
    int other_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one bus-clock tick through the prescaler; true on an unmasked expiry
    function automatic bit divided_tick();
        int v;
        int ratio;
        int nxt;
        v = int'({tmr_divide[3], tmr_divide[1:0]});
        ratio = (v == 7) ? 1 : (2 << v);
        nxt = int'(tmr_prescale) + 1;
        if (nxt < ratio) begin
            tmr_prescale = PRE_WIDTH'(nxt);
            return 1'b0;
        end
        tmr_prescale = '0;
        if (tmr_current == '0) begin
            return 1'b0;
        end
        tmr_current = tmr_current - 1'b1;
        if (tmr_current != '0) begin
            return 1'b0;
        end
        if (tmr_periodic) begin
            tmr_current = tmr_initial;
        end
        return !tmr_masked;
    endfunction

    function automatic t_out_word timer_event(input logic [1:0] kind, input logic [1:0] sel,
                                              input logic [31:0] data);
        t_out_word w;
        w = '0;
        case (kind)
            KIND_TICK: begin
                if (divided_tick()) begin
                    w.irq_fire = 1'b1;
                    w.irq_vector = tmr_vector;
                end
            end
            KIND_WRITE: begin
                case (sel)
                    REG_LVT: begin
                        tmr_vector = data[VEC_WIDTH-1:0];
                        tmr_masked = data[MASK_BIT];
                        tmr_periodic = data[PERIODIC_BIT];
                    end
                    REG_INITIAL: begin
                        tmr_initial = data[COUNT_WIDTH-1:0];
                        tmr_current = data[COUNT_WIDTH-1:0];
                        tmr_prescale = '0;
                    end
                    REG_DIVIDE: tmr_divide = data[DIV_WIDTH-1:0] & DIVIDE_KEEP;
                    default: ;
                endcase
            end
            KIND_READ: begin
                case (sel)
                    REG_LVT: w.read_data = DATA_WIDTH'(tmr_vector)
                                         | (DATA_WIDTH'(tmr_masked) << MASK_BIT)
                                         | (DATA_WIDTH'(tmr_periodic) << PERIODIC_BIT);
                    REG_INITIAL: w.read_data = DATA_WIDTH'(tmr_initial);
                    REG_CURRENT: w.read_data = DATA_WIDTH'(tmr_current);
                    default: w.read_data = DATA_WIDTH'(tmr_divide);
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic note_fail(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch %0d at cycle %0d: %s expected %h got %h",
                     fail_count, cycle_count, what, want, got);
        end
    endtask

    task automatic send_event(input logic [1:0] kind, input logic [1:0] sel,
                              input logic [31:0] data, input bit pinned,
                              input t_out_word pinned_word);
        t_out_word predicted;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.reg_select <= sel;
        in_ch.write_data <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = timer_event(kind, sel, data);
        pending_words.push_back(pinned ? pinned_word : predicted);
        case (kind)
            KIND_TICK:  tick_count++;
            KIND_WRITE: write_count++;
            KIND_READ:  read_count++;
            default:    other_count++;
        endcase
    endtask

    // mostly ticks with short counts and fast dividers so expiries come often
    task automatic pick_event(output logic [1:0] kind, output logic [1:0] sel,
                              output logic [31:0] data);
        int r;
        int pick;
        logic [2:0] v;
        r = $urandom_range(0, 99);
        sel = 2'($urandom);
        data = $urandom;
        if (r < 55) begin
            kind = KIND_TICK;
        end else if (r < 67) begin
            kind = KIND_WRITE;
            sel = REG_INITIAL;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                data = $urandom_range(1, 8);
            end else if (pick < 85) begin
                data = $urandom_range(9, 40);
            end else if (pick < 90) begin
                data = '0;
            end
        end else if (r < 75) begin
            kind = KIND_WRITE;
            sel = REG_LVT;
            data[MASK_BIT] = ($urandom_range(0, 9) < 4);
        end else if (r < 82) begin
            kind = KIND_WRITE;
            sel = REG_DIVIDE;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                v = 3'd7;
            end else if (pick < 7) begin
                v = 3'd0;
            end else if (pick < 9) begin
                v = 3'($urandom_range(1, 2));
            end else begin
                v = 3'($urandom_range(3, 6));
            end
            data[3] = v[2];
            data[1:0] = v[1:0];
        end else if (r < 84) begin
            kind = KIND_WRITE;
            sel = REG_CURRENT;
        end else if (r < 96) begin
            kind = KIND_READ;
        end else begin
            kind = KIND_NONE;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.read_data  = out_ch.read_data;
            got.irq_fire   = out_ch.irq_fire;
            got.irq_vector = out_ch.irq_vector;
            if (pending_words.size() == 0) begin
                note_fail("unexpected word, read_data", '0, got.read_data);
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.irq_fire) irq_count++;
                if (got.read_data !== want.read_data)
                    note_fail("read_data", want.read_data, got.read_data);
                if (got.irq_fire !== want.irq_fire)
                    note_fail("irq_fire", 32'(want.irq_fire), 32'(got.irq_fire));
                if (got.irq_vector !== want.irq_vector)
                    note_fail("irq_vector", 32'(want.irq_vector), 32'(got.irq_vector));
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                if (hold == 0) out_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                out_ch.ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, pending_words.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int ph;
        int n;
        int gap_by_phase [N_PHASES];
        int stall_by_phase [N_PHASES];
        logic [1:0]  k;
        logic [1:0]  s;
        logic [31:0] d;
        gap_by_phase   = '{15, 0, 30, 5, 20, 0};
        stall_by_phase = '{15, 0, 10, 40, 20, 0};
        tmr_initial  = '0;
        tmr_current  = '0;
        tmr_vector   = '0;
        tmr_masked   = 1'b1;
        tmr_periodic = 1'b0;
        tmr_divide   = '0;
        tmr_prescale = '0;
        fail_count = 0;
        words_checked = 0;
        irq_count = 0;
        tick_count = 0;
        write_count = 0;
        read_count = 0;
        other_count = 0;
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_TICK;
        in_ch.reg_select <= REG_LVT;
        in_ch.write_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIRECTED; n++) begin
            send_event(DIRECTED_ROWS[n].kind, DIRECTED_ROWS[n].sel, DIRECTED_ROWS[n].data,
                       DIRECTED_ROWS[n].pinned, DIRECTED_ROWS[n].word);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            tx_gap_pct = gap_by_phase[ph];
            rx_stall_pct = stall_by_phase[ph];
            for (n = 0; n < PHASE_EVENTS; n++) begin
                pick_event(k, s, d);
                send_event(k, s, d, 1'b0, '0);
            end
            if (ph == 2) begin
                // hold off until the output side has caught up completely
                in_ch.valid <= 1'b0;
                while (pending_words.size() != 0) @(posedge i_clk);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d bus events: %0d ticks, %0d writes, %0d reads, %0d of unknown kind",
                 tick_count + write_count + read_count + other_count,
                 tick_count, write_count, read_count, other_count);
        $display("%0d result words checked, %0d interrupts delivered, %0d mismatches",
                 words_checked, irq_count, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/apict_pkg.sv
hw/rtl/apict_in_if.sv
hw/rtl/apict_out_if.sv
hw/rtl/apic_countdown_timer.sv
bench/apic_countdown_timer_tb.sv
